@@ rtl/lrusc_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU slot cache package
// Shared payload types, command and status codes, and the control and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lrusc_pkg;

	// Field widths of the command and result beats.
	localparam int CMD_W  = 2;
	localparam int KEY_W  = 32;
	localparam int HND_W  = 32;
	localparam int STAT_W = 3;
	localparam int SLOT_W = 4;
	localparam int CFG_W  = 5;

	// Value of slots_in_use after reset.
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNLOAD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
	localparam logic [STAT_W-1:0] ST_INSERT   = 3'd1;
	localparam logic [STAT_W-1:0] ST_FAIL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_UNLOADED = 3'd3;
	localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd4;
	localparam logic [STAT_W-1:0] ST_CLR_REL  = 3'd5;
	localparam logic [STAT_W-1:0] ST_CLR_DONE = 3'd6;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;
		logic [HND_W-1:0] fetched_handle;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [HND_W-1:0]  handle;
		logic              release_valid;
		logic [HND_W-1:0]  released_handle;
		logic              last;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load_item;
		logic              scan_step;
		logic              clr_step;
		logic              set_s_hit;
		logic              set_s_back;
		logic              take_pop;
		logic              rd_slot;
		logic              unlink;
		logic              inval;
		logic              push;
		logic              pop_rd;
		logic              dec_count;
		logic              fill;
		logic              link_a;
		logic              link_b;
		logic              save_rel;
		logic              reb_start;
		logic              reb_step;
		logic              emit;
		logic [STAT_W-1:0] emit_status;
		logic              emit_noslot;
		logic              emit_last;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] item_cmd;
		logic             hit;
		logic             scan_done;
		logic             clr_vld;
		logic             front_is_s;
		logic             free_empty;
		logic             back_none;
		logic             fetch_zero;
		logic             reb_done;
	} dp_stat_t;

endpackage

@@ rtl/lrusc_ctrl.sv @@
// ----------------------------------------------------------------------------
// LRU slot cache controller
// State machine that sequences the search, list updates, free stack
// operations and clear sweep of the datapath, one step per cycle.
// ----------------------------------------------------------------------------
module lrusc_ctrl
	import lrusc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] start_cmd,
	input  dp_stat_t         stat,
	output dp_cmd_t          cmd,
	output logic             busy
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_INIT  = 4'd1;
	localparam logic [3:0] S_SRCH  = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_UNL   = 4'd4;
	localparam logic [3:0] S_LA    = 4'd5;
	localparam logic [3:0] S_LB    = 4'd6;
	localparam logic [3:0] S_UFIN  = 4'd7;
	localparam logic [3:0] S_ERD   = 4'd8;
	localparam logic [3:0] S_EFIN  = 4'd9;
	localparam logic [3:0] S_PCHK  = 4'd10;
	localparam logic [3:0] S_POP   = 4'd11;
	localparam logic [3:0] S_PDEC  = 4'd12;
	localparam logic [3:0] S_HEMIT = 4'd13;
	localparam logic [3:0] S_CLR   = 4'd14;
	localparam logic [3:0] S_REB   = 4'd15;

	logic [3:0] state_q, state_d;
	logic       ins_q, ins_d;

	// State and path flag registers; reset starts the free stack build.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ins_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ins_q   <= ins_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		ins_d   = ins_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					ins_d         = 1'b0;
					case (start_cmd)
						CMD_LOAD, CMD_UNLOAD: state_d = S_SRCH;
						CMD_CLEAR:            state_d = S_CLR;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_INIT: begin
				cmd.reb_step = 1'b1;
				if (stat.reb_done) begin
					state_d = S_IDLE;
				end
			end
			S_SRCH: begin
				cmd.scan_step = 1'b1;
				if (stat.hit) begin
					cmd.set_s_hit = 1'b1;
					state_d       = S_RD;
				end else if (stat.scan_done) begin
					if (stat.item_cmd == CMD_UNLOAD) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = ST_ABSENT;
						cmd.emit_last   = 1'b1;
						state_d         = S_IDLE;
					end else if (stat.free_empty && !stat.back_none) begin
						cmd.set_s_back = 1'b1;
						state_d        = S_ERD;
					end else begin
						state_d = S_PCHK;
					end
				end
			end
			S_RD: begin
				cmd.rd_slot = 1'b1;
				if (stat.item_cmd == CMD_UNLOAD) begin
					state_d = S_UFIN;
				end else if (stat.front_is_s) begin
					state_d = S_HEMIT;
				end else begin
					state_d = S_UNL;
				end
			end
			S_UNL: begin
				cmd.unlink = 1'b1;
				state_d    = S_LA;
			end
			S_LA: begin
				cmd.link_a = 1'b1;
				state_d    = S_LB;
			end
			S_LB: begin
				cmd.link_b      = 1'b1;
				cmd.emit        = 1'b1;
				cmd.emit_status = ins_q ? ST_INSERT : ST_HIT;
				cmd.emit_last   = 1'b1;
				state_d         = S_IDLE;
			end
			S_HEMIT: begin
				cmd.emit        = 1'b1;
				cmd.emit_status = ST_HIT;
				cmd.emit_last   = 1'b1;
				state_d         = S_IDLE;
			end
			S_UFIN: begin
				cmd.unlink      = 1'b1;
				cmd.inval       = 1'b1;
				cmd.push        = 1'b1;
				cmd.emit        = 1'b1;
				cmd.emit_status = ST_UNLOADED;
				cmd.emit_last   = 1'b1;
				state_d         = S_IDLE;
			end
			S_ERD: begin
				cmd.rd_slot = 1'b1;
				state_d     = S_EFIN;
			end
			S_EFIN: begin
				cmd.unlink   = 1'b1;
				cmd.inval    = 1'b1;
				cmd.push     = 1'b1;
				cmd.save_rel = 1'b1;
				state_d      = S_PCHK;
			end
			S_PCHK: begin
				if (stat.free_empty) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_FAIL;
					cmd.emit_noslot = 1'b1;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d    = S_POP;
				end
			end
			S_POP: begin
				cmd.take_pop = 1'b1;
				state_d      = S_PDEC;
			end
			S_PDEC: begin
				if (stat.fetch_zero) begin
					// The slot stays on the stack: the count is left alone.
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_FAIL;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.fill      = 1'b1;
					cmd.dec_count = 1'b1;
					ins_d         = 1'b1;
					state_d       = S_LA;
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_vld) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_CLR_REL;
				end
				if (stat.scan_done) begin
					cmd.reb_start = 1'b1;
					state_d       = S_REB;
				end
			end
			S_REB: begin
				cmd.reb_step = 1'b1;
				if (stat.reb_done) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_CLR_DONE;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/lrusc_dp.sv @@
// ----------------------------------------------------------------------------
// LRU slot cache datapath
// Key, handle and link memories, the free stack memory, valid bits, list
// head and tail registers, and the registered result beat.
// ----------------------------------------------------------------------------
module lrusc_dp
	import lrusc_pkg::*;
#(
	parameter int SLOTS       = 16,
	parameter int KEY_BITS    = 32,
	parameter int HANDLE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            item,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	output result_t          result,
	output logic             result_valid
);

	localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW      = $clog2(SLOTS + 1);
	localparam int KW      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int HW      = (HANDLE_BITS < HND_W) ? HANDLE_BITS : HND_W;
	localparam int RESET_N = (SLOTS < 16) ? SLOTS : 16;
	localparam logic [LW-1:0] NONE     = LW'(SLOTS);
	localparam logic [LW-1:0] ONE      = LW'(1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	// Memories.
	logic [KW-1:0] key_mem    [SLOTS];
	logic [HW-1:0] handle_mem [SLOTS];
	logic [LW-1:0] newer_mem  [SLOTS];
	logic [LW-1:0] older_mem  [SLOTS];
	logic [IW-1:0] stack_mem  [SLOTS];

	// Item and working registers.
	logic [CMD_W-1:0] cmd_q;
	logic [KW-1:0]    key_q;
	logic [HW-1:0]    fh_q;
	logic [CFG_W-1:0] cfg_q;
	logic [LW-1:0]    scan_cnt_q;
	logic [IW-1:0]    idx_s1;
	logic             vld_s1;
	logic             cvld_s1;
	logic [KW-1:0]    key_rd_s1;
	logic [IW-1:0]    s_q;
	logic [LW-1:0]    front_q;
	logic [LW-1:0]    back_q;
	logic [LW-1:0]    count_q;
	logic [SLOTS-1:0] valid_q;
	logic             rv_q;
	logic [HW-1:0]    rh_q;
	logic [HW-1:0]    hnd_rd_q;
	logic [LW-1:0]    newer_rd_q;
	logic [LW-1:0]    older_rd_q;
	logic [IW-1:0]    stk_rd_q;
	logic [LW-1:0]    reb_n_q;
	logic [LW-1:0]    reb_cnt_q;
	result_t          res_q;
	logic             res_vld_q;

	logic [IW-1:0] scan_idx;
	logic          scan_live;
	logic [LW-1:0] eff_n;
	logic [IW-1:0] hnd_addr;
	logic          push_ok;

	logic          nw_we, ow_we, kw_we, sw_we;
	logic [IW-1:0] nw_addr, ow_addr, sw_addr;
	logic [LW-1:0] nw_data, ow_data;
	logic [IW-1:0] sw_data;
	result_t       res_d;

	assign scan_idx  = scan_cnt_q[IW-1:0];
	assign scan_live = (scan_cnt_q < NONE);
	assign hnd_addr  = cmd.clr_step ? scan_idx : s_q;
	assign push_ok   = cmd.push && (count_q < NONE);

	// Slot count used for a rebuild, clamped to the legal range.
	always_comb begin
		if (cfg_q == '0) begin
			eff_n = ONE;
		end else if (32'(cfg_q) > SLOTS) begin
			eff_n = NONE;
		end else begin
			eff_n = LW'(cfg_q);
		end
	end

	// Status toward the controller.
	assign stat.item_cmd   = cmd_q;
	assign stat.hit        = vld_s1 && valid_q[idx_s1] && (key_rd_s1 == key_q);
	assign stat.scan_done  = vld_s1 && (idx_s1 == LAST_IDX);
	assign stat.clr_vld    = vld_s1 && cvld_s1;
	assign stat.front_is_s = (front_q == LW'(s_q));
	assign stat.free_empty = (count_q == '0);
	assign stat.back_none  = (back_q == NONE);
	assign stat.fetch_zero = (fh_q == '0);
	assign stat.reb_done   = (reb_cnt_q == reb_n_q - ONE);

	// Link memory write ports: unlink, then link at the front in two steps.
	always_comb begin
		nw_we   = 1'b0;
		nw_addr = s_q;
		nw_data = NONE;
		ow_we   = 1'b0;
		ow_addr = s_q;
		ow_data = front_q;
		if (cmd.unlink) begin
			ow_we   = (newer_rd_q != NONE);
			ow_addr = newer_rd_q[IW-1:0];
			ow_data = older_rd_q;
			nw_we   = (older_rd_q != NONE);
			nw_addr = older_rd_q[IW-1:0];
			nw_data = newer_rd_q;
		end else if (cmd.link_a) begin
			nw_we = 1'b1;
			ow_we = 1'b1;
		end else if (cmd.link_b) begin
			nw_we   = (front_q != NONE);
			nw_addr = front_q[IW-1:0];
			nw_data = LW'(s_q);
		end
	end

	// Free stack write port: push or rebuild.
	always_comb begin
		sw_we   = 1'b0;
		sw_addr = count_q[IW-1:0];
		sw_data = s_q;
		if (cmd.reb_step) begin
			sw_we   = 1'b1;
			sw_addr = reb_cnt_q[IW-1:0];
			sw_data = IW'(reb_n_q - reb_cnt_q - ONE);
		end else if (push_ok) begin
			sw_we = 1'b1;
		end
	end

	assign kw_we = cmd.fill;

	// Key and handle memories.
	always_ff @(posedge clk) begin
		if (kw_we) begin
			key_mem[s_q]    <= key_q;
			handle_mem[s_q] <= fh_q;
		end
		if (cmd.scan_step && scan_live) begin
			key_rd_s1 <= key_mem[scan_idx];
		end
		if (cmd.rd_slot || (cmd.clr_step && scan_live)) begin
			hnd_rd_q <= handle_mem[hnd_addr];
		end
	end

	// Link memories.
	always_ff @(posedge clk) begin
		if (nw_we) begin
			newer_mem[nw_addr] <= nw_data;
		end
		if (ow_we) begin
			older_mem[ow_addr] <= ow_data;
		end
		if (cmd.rd_slot) begin
			newer_rd_q <= newer_mem[s_q];
			older_rd_q <= older_mem[s_q];
		end
	end

	// Free stack memory.
	always_ff @(posedge clk) begin
		if (sw_we) begin
			stack_mem[sw_addr] <= sw_data;
		end
		if (cmd.pop_rd) begin
			stk_rd_q <= stack_mem[IW'(count_q - ONE)];
		end
	end

	// Item capture and working payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q <= item.cmd;
			key_q <= item.key[KW-1:0];
			fh_q  <= item.fetched_handle[HW-1:0];
		end
		if (cmd.scan_step || cmd.clr_step) begin
			idx_s1  <= scan_idx;
			cvld_s1 <= cmd.clr_step && valid_q[scan_idx];
		end
		if (cmd.set_s_hit) begin
			s_q <= idx_s1;
		end else if (cmd.set_s_back) begin
			s_q <= back_q[IW-1:0];
		end else if (cmd.take_pop) begin
			s_q <= stk_rd_q;
		end
		if (cmd.load_item) begin
			rh_q <= '0;
		end else if (cmd.save_rel) begin
			rh_q <= hnd_rd_q;
		end
		res_q <= res_d;
	end

	// Control registers: valid bits, list ends, counts and sweeps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= CFG_RESET;
			scan_cnt_q <= '0;
			vld_s1     <= 1'b0;
			front_q    <= NONE;
			back_q     <= NONE;
			count_q    <= LW'(RESET_N);
			valid_q    <= '0;
			rv_q       <= 1'b0;
			reb_n_q    <= LW'(RESET_N);
			reb_cnt_q  <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			res_vld_q <= cmd.emit;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			// Scan counter shared by the key search and the clear sweep.
			if (cmd.load_item) begin
				scan_cnt_q <= '0;
				vld_s1     <= 1'b0;
			end else if (cmd.scan_step || cmd.clr_step) begin
				vld_s1 <= scan_live;
				if (scan_live) begin
					scan_cnt_q <= scan_cnt_q + ONE;
				end
			end
			// Valid bits.
			if (cmd.clr_step && scan_live) begin
				valid_q[scan_idx] <= 1'b0;
			end else if (cmd.inval) begin
				valid_q[s_q] <= 1'b0;
			end else if (cmd.fill) begin
				valid_q[s_q] <= 1'b1;
			end
			// Release flag of an eviction.
			if (cmd.load_item) begin
				rv_q <= 1'b0;
			end else if (cmd.save_rel) begin
				rv_q <= 1'b1;
			end
			// List ends.
			if (cmd.unlink) begin
				if (newer_rd_q == NONE) begin
					front_q <= older_rd_q;
				end
				if (older_rd_q == NONE) begin
					back_q <= newer_rd_q;
				end
			end else if (cmd.link_b) begin
				if (front_q == NONE) begin
					back_q <= LW'(s_q);
				end
				front_q <= LW'(s_q);
			end else if (cmd.reb_start) begin
				front_q <= NONE;
				back_q  <= NONE;
			end
			// Free count.
			if (cmd.reb_start) begin
				count_q <= eff_n;
			end else if (push_ok) begin
				count_q <= count_q + ONE;
			end else if (cmd.dec_count) begin
				count_q <= count_q - ONE;
			end
			// Rebuild sweep.
			if (cmd.reb_start) begin
				reb_n_q   <= eff_n;
				reb_cnt_q <= '0;
			end else if (cmd.reb_step) begin
				reb_cnt_q <= reb_cnt_q + ONE;
			end
		end
	end

	// Result beat fields by status.
	always_comb begin
		res_d                 = '0;
		res_d.status          = cmd.emit_status;
		res_d.last            = cmd.emit_last;
		unique case (cmd.emit_status)
			ST_HIT: begin
				res_d.slot   = SLOT_W'(s_q);
				res_d.handle = HND_W'(hnd_rd_q);
			end
			ST_INSERT: begin
				res_d.slot            = SLOT_W'(s_q);
				res_d.handle          = HND_W'(fh_q);
				res_d.release_valid   = rv_q;
				res_d.released_handle = HND_W'(rh_q);
			end
			ST_FAIL: begin
				res_d.slot            = cmd.emit_noslot ? '0 : SLOT_W'(s_q);
				res_d.release_valid   = rv_q;
				res_d.released_handle = HND_W'(rh_q);
			end
			ST_UNLOADED: begin
				res_d.slot            = SLOT_W'(s_q);
				res_d.release_valid   = 1'b1;
				res_d.released_handle = HND_W'(hnd_rd_q);
			end
			ST_CLR_REL: begin
				res_d.slot            = SLOT_W'(idx_s1);
				res_d.release_valid   = 1'b1;
				res_d.released_handle = HND_W'(hnd_rd_q);
			end
			default: begin
				res_d.slot = '0;
			end
		endcase
	end

	assign result       = res_q;
	assign result_valid = res_vld_q;

endmodule

@@ rtl/lru_slot_cache_with_free_stack.sv @@
// ----------------------------------------------------------------------------
// LRU slot cache with free stack
// Fully associative cache of key and handle pairs kept in recency order,
// with a last-in-first-out stack of free slots.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each result beat is
// shown for one cycle with result_valid high and must be taken then, and the
// last beat of a command has last set. The key search reads the key memory
// one slot per cycle; the last beat of a command shows in the cycle in which
// busy has just fallen.
// A clear walks all SLOTS slots, giving one release beat per valid entry,
// then rewrites the free stack one entry per cycle for the slot count in use
// and ends with a clear done beat. After reset the free stack is written the
// same way, with busy high. A write of slots_in_use takes effect at the next
// clear.
module lru_slot_cache_with_free_stack
	import lrusc_pkg::*;
#(
	parameter int SLOTS       = 16,
	parameter int KEY_BITS    = 32,
	parameter int HANDLE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            item,
	output result_t          result,
	output logic             result_valid,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// Sequencer.
	lrusc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_cmd (item.cmd),
		.stat      (dp_stat),
		.cmd       (dp_cmd),
		.busy      (busy)
	);

	// Storage and result datapath.
	lrusc_dp #(
		.SLOTS       (SLOTS),
		.KEY_BITS    (KEY_BITS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.result       (result),
		.result_valid (result_valid)
	);

	// An accepted load, unload or clear always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.cmd == CMD_LOAD || item.cmd == CMD_UNLOAD
			|| item.cmd == CMD_CLEAR)) |=> busy)
		else $error("block not busy after accepting a command");

	// A result beat only follows a cycle in which the block was working.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result beat without a command in progress");

	// The last beat of a command is never directly followed by another beat.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |=> !result_valid)
		else $error("result beat right after the last beat of a command");

	// A clear release beat is never the last beat of its command.
	a_clr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == ST_CLR_REL) |-> !result.last)
		else $error("clear release marked as last beat");

endmodule
